### sv/lpcp_pkg.sv
// Shared types, widths and constants for the lidar point camera projection.
// Used by every module of the block; depends on nothing.
package lpcp_pkg;

	// Field widths
	localparam int CW     = 24;           // lidar coordinate width
	localparam int RW     = 18;           // rotation element, signed Q2.16
	localparam int TW     = 21;           // translation element, signed mm
	localparam int FW     = 24;           // focal / center, unsigned Q16.8
	localparam int SW     = 12;           // image width / height
	localparam int PROD_W = CW + RW;      // rotation product
	localparam int CAM_W  = PROD_W + 3;   // camera coordinate, Q.16 mm
	localparam int QW     = CAM_W - 14;   // camera coordinate, Q.2 mm
	localparam int NUM_W  = FW + QW + 3;  // projection numerator
	localparam int DEN_W  = QW + 4;       // 16 * depth
	localparam int QB     = 17;           // quotient bits of the divider
	localparam int REM_W  = DEN_W + QB;   // divider remainder
	localparam int PIX_W  = 18;           // output pixel, 1/16 pixel

	// Config port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 63;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROT0  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROT1  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROT2  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRANS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PRINC = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE = 3'd6;

	// Register reset values
	localparam logic [3*RW-1:0]   ROT0_RST  = 54'd65536;
	localparam logic [3*RW-1:0]   ROT1_RST  = 54'd17179869184;
	localparam logic [3*RW-1:0]   ROT2_RST  = 54'd4503599627370496;
	localparam logic [3*TW-1:0]   TRANS_RST = 63'd0;
	localparam logic [2*FW-1:0]   FOCAL_RST = 48'd4295223296000;
	localparam logic [2*FW-1:0]   PRINC_RST = 48'd0;
	localparam logic [2*SW-1:0]   IMAGE_RST = 24'd1966720;

	// Depth floor (100 mm in Q.16) and cull margin (20 px in 1/16 px)
	localparam logic signed [CAM_W-1:0] MIN_Z     = CAM_W'(100 * 65536);
	localparam logic [QB-1:0]           MARGIN16  = QB'(320);
	localparam logic [PIX_W-1:0]        MARGIN16P = PIX_W'(320);

	typedef struct packed {
		logic [3*RW-1:0] rot0;
		logic [3*RW-1:0] rot1;
		logic [3*RW-1:0] rot2;
		logic [3*TW-1:0] trans;
		logic [2*FW-1:0] focal;
		logic [2*FW-1:0] princ;
		logic [2*SW-1:0] image;
	} cfg_t;

	// Per-beat sideband: valid travels with the data, keep drops culled points
	typedef struct packed {
		logic                 valid;
		logic                 keep;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} meta_t;

	typedef struct packed {
		meta_t              meta;
		logic [DEN_W-1:0]   den;
		logic [REM_W-1:0]   rem_u;
		logic [REM_W-1:0]   rem_v;
		logic [QB-1:0]      qu;
		logic [QB-1:0]      qv;
	} div_t;

endpackage

### sv/lidar_point_camera_projection_top.sv
// Lidar point to camera pixel projection with frustum cull.
// Pipeline: 6 arithmetic stages, 17 divider stages, output register.
// Throughput: one point per cycle; the whole pipeline holds while the output
// beat waits. Reset clears all valid bits and loads the default calibration
// (identity rotation, 640 x 480 image).
// Depends on lpcp_pkg, lpcp_xform, lpcp_proj and lpcp_div.
module lidar_point_camera_projection_top import lpcp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wen,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [CW-1:0]    point_x,
	input  logic signed [CW-1:0]    point_y,
	input  logic signed [CW-1:0]    point_z,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [PIX_W-1:0] pixel_u,
	output logic signed [PIX_W-1:0] pixel_v,
	output logic signed [CW-1:0]    kept_x,
	output logic signed [CW-1:0]    kept_y,
	output logic signed [CW-1:0]    kept_z
);

	cfg_t                 cfg_q;
	logic                 adv;
	meta_t                meta_in, meta_s3;
	logic signed [QW-1:0] xq_s3, yq_s3, zq_s3;
	div_t                 div_s6, div_last;
	logic [QB-1:0]        lim_u, lim_v;
	logic                 hit;
	logic                 valid_q;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rot0  <= ROT0_RST;
			cfg_q.rot1  <= ROT1_RST;
			cfg_q.rot2  <= ROT2_RST;
			cfg_q.trans <= TRANS_RST;
			cfg_q.focal <= FOCAL_RST;
			cfg_q.princ <= PRINC_RST;
			cfg_q.image <= IMAGE_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_ROT0:  cfg_q.rot0  <= cfg_data[3*RW-1:0];
				REG_ROT1:  cfg_q.rot1  <= cfg_data[3*RW-1:0];
				REG_ROT2:  cfg_q.rot2  <= cfg_data[3*RW-1:0];
				REG_TRANS: cfg_q.trans <= cfg_data[3*TW-1:0];
				REG_FOCAL: cfg_q.focal <= cfg_data[2*FW-1:0];
				REG_PRINC: cfg_q.princ <= cfg_data[2*FW-1:0];
				REG_IMAGE: cfg_q.image <= cfg_data[2*SW-1:0];
				default: ;
			endcase
		end
	end

	// Whole pipeline moves when the output register is free
	assign adv      = !valid_q || out_ready;
	assign in_ready = adv;

	assign meta_in.valid = in_valid;
	assign meta_in.keep  = 1'b1;
	assign meta_in.x     = point_x;
	assign meta_in.y     = point_y;
	assign meta_in.z     = point_z;

	lpcp_xform u_xform (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.cfg     (cfg_q),
		.meta_in (meta_in),
		.meta_s3 (meta_s3),
		.xq_s3   (xq_s3),
		.yq_s3   (yq_s3),
		.zq_s3   (zq_s3)
	);

	lpcp_proj u_proj (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.cfg     (cfg_q),
		.meta_in (meta_s3),
		.xq      (xq_s3),
		.yq      (yq_s3),
		.zq      (zq_s3),
		.div_s6  (div_s6)
	);

	lpcp_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.div_in  (div_s6),
		.div_out (div_last)
	);

	// Upper image bound in biased quotient units: 16*size + 640
	assign lim_u = {1'b0, cfg_q.image[SW-1:0], 4'b0000} + (MARGIN16 << 1);
	assign lim_v = {1'b0, cfg_q.image[2*SW-1:SW], 4'b0000} + (MARGIN16 << 1);
	assign hit   = div_last.meta.valid && div_last.meta.keep
		&& (div_last.qu < lim_u) && (div_last.qv < lim_v);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= hit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pixel_u <= {1'b0, div_last.qu} - MARGIN16P;
			pixel_v <= {1'b0, div_last.qv} - MARGIN16P;
			kept_x  <= div_last.meta.x;
			kept_y  <= div_last.meta.y;
			kept_z  <= div_last.meta.z;
		end
	end

	assign out_valid = valid_q;

	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output register state");

	a_u_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pixel_u >= -PIX_W'(320)))
		else $error("pixel_u below left margin");

	a_v_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pixel_v >= -PIX_W'(320)))
		else $error("pixel_v below top margin");

	a_drop_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !div_last.meta.valid) |=> !out_valid)
		else $error("result emitted without a beat");

endmodule

### sv/lpcp_xform.sv
// Rigid transform stages: rotate, translate, depth test, round to Q.2 mm.
// Depends on lpcp_pkg.
module lpcp_xform import lpcp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  cfg_t                 cfg,
	input  meta_t                meta_in,
	output meta_t                meta_s3,
	output logic signed [QW-1:0] xq_s3,
	output logic signed [QW-1:0] yq_s3,
	output logic signed [QW-1:0] zq_s3
);

	logic [3*RW-1:0]             rows [3];
	logic signed [CW-1:0]        pnt [3];
	logic signed [PROD_W-1:0]    prod_s1 [3][3];
	logic signed [TW-1:0]        t_s1 [3];
	meta_t                       meta_s1;
	logic signed [CAM_W-1:0]     cam_s2 [3];
	meta_t                       meta_s2;
	logic signed [CAM_W-1:0]     rnd [3];

	assign rows[0] = cfg.rot0;
	assign rows[1] = cfg.rot1;
	assign rows[2] = cfg.rot2;
	assign pnt[0]  = meta_in.x;
	assign pnt[1]  = meta_in.y;
	assign pnt[2]  = meta_in.z;

	// Stage 1: nine rotation products
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s1[r][j] <= $signed(rows[r][RW*j +: RW]) * pnt[j];
				end
				t_s1[r] <= $signed(cfg.trans[TW*r +: TW]);
			end
		end
	end

	// Stage 2: sum products and translation in Q.16 mm
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				cam_s2[r] <= (CAM_W'(t_s1[r]) <<< 16) + CAM_W'(prod_s1[r][0])
					+ CAM_W'(prod_s1[r][1]) + CAM_W'(prod_s1[r][2]);
			end
		end
	end

	// Round half up to Q.2 mm
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			rnd[r] = cam_s2[r] + CAM_W'(8192);
		end
	end

	// Stage 3: rounded coordinates and depth cull
	always_ff @(posedge clk) begin
		if (adv) begin
			xq_s3 <= rnd[0][CAM_W-1:14];
			yq_s3 <= rnd[1][CAM_W-1:14];
			zq_s3 <= rnd[2][CAM_W-1:14];
		end
	end

	// Advance sideband; drop points at or below the depth floor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
			meta_s2 <= '0;
			meta_s3 <= '0;
		end else if (adv) begin
			meta_s1 <= meta_in;
			meta_s2 <= meta_s1;
			meta_s3 <= {meta_s2.valid, meta_s2.keep & (cam_s2[2] > MIN_Z),
				meta_s2.x, meta_s2.y, meta_s2.z};
		end
	end

endmodule

### sv/lpcp_proj.sv
// Projection numerators, margin offset and range screening ahead of the divider.
// Depends on lpcp_pkg.
module lpcp_proj import lpcp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  cfg_t                 cfg,
	input  meta_t                meta_in,
	input  logic signed [QW-1:0] xq,
	input  logic signed [QW-1:0] yq,
	input  logic signed [QW-1:0] zq,
	output div_t                 div_s6
);

	logic signed [NUM_W-1:0] pu_s4, cu_s4, pv_s4, cv_s4;
	logic [DEN_W-1:0]        den_s4, den_s5;
	meta_t                   meta_s4, meta_s5;
	logic [NUM_W-1:0]        off;
	logic signed [NUM_W-1:0] nu_s5, nv_s5;
	logic [NUM_W-1:0]        lim;
	logic                    ok_u, ok_v;

	// Stage 4: fx*X, (cx+8)*Z and the same for v
	always_ff @(posedge clk) begin
		if (adv) begin
			pu_s4  <= $signed({1'b0, cfg.focal[FW-1:0]}) * xq;
			pv_s4  <= $signed({1'b0, cfg.focal[2*FW-1:FW]}) * yq;
			cu_s4  <= $signed({1'b0, {1'b0, cfg.princ[FW-1:0]} + (FW+1)'(8)}) * zq;
			cv_s4  <= $signed({1'b0, {1'b0, cfg.princ[2*FW-1:FW]} + (FW+1)'(8)}) * zq;
			den_s4 <= {1'b0, zq[QW-2:0], 4'b0000};
		end
	end

	// Bias by 320*D so the lower margin maps to a zero quotient
	assign off = (NUM_W'(den_s4) << 8) + (NUM_W'(den_s4) << 6);

	// Stage 5: biased numerators
	always_ff @(posedge clk) begin
		if (adv) begin
			nu_s5  <= pu_s4 + cu_s4 + $signed(off);
			nv_s5  <= pv_s4 + cv_s4 + $signed(off);
			den_s5 <= den_s4;
		end
	end

	// Quotient must land in [0, 2^17)
	assign lim  = NUM_W'(den_s5) << QB;
	assign ok_u = !nu_s5[NUM_W-1] && (nu_s5 < lim);
	assign ok_v = !nv_s5[NUM_W-1] && (nv_s5 < lim);

	// Advance sideband
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s4 <= '0;
			meta_s5 <= '0;
		end else if (adv) begin
			meta_s4 <= meta_in;
			meta_s5 <= meta_s4;
		end
	end

	// Stage 6: divider entry; drop points whose quotient leaves the range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_s6 <= '0;
		end else if (adv) begin
			div_s6 <= {meta_s5.valid, meta_s5.keep & ok_u & ok_v,
				meta_s5.x, meta_s5.y, meta_s5.z,
				den_s5, nu_s5[REM_W-1:0], nv_s5[REM_W-1:0], QB'(0), QB'(0)};
		end
	end

endmodule

### sv/lpcp_div.sv
// Pipelined restoring divider, one quotient bit per stage, u and v together.
// Depends on lpcp_pkg.
module lpcp_div import lpcp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  div_t div_in,
	output div_t div_out
);

	div_t st [QB+1];

	assign st[0]   = div_in;
	assign div_out = st[QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		localparam int B = QB - 1 - k;
		logic [REM_W-1:0] sh;
		logic             ge_u, ge_v;

		assign sh   = REM_W'(st[k].den) << B;
		assign ge_u = st[k].rem_u >= sh;
		assign ge_v = st[k].rem_v >= sh;

		// Subtract shifted divisor where it fits; sideband advances alongside
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				st[k+1] <= '0;
			end else if (adv) begin
				st[k+1] <= {st[k].meta, st[k].den,
					ge_u ? st[k].rem_u - sh : st[k].rem_u,
					ge_v ? st[k].rem_v - sh : st[k].rem_v,
					st[k].qu | (QB'(ge_u) << B),
					st[k].qv | (QB'(ge_v) << B)};
			end
		end
	end

endmodule
